[rtl/turtle_path_interpreter_assert.svh]
// Assertion macros for the turtle path interpreter.
// Each macro samples on clk and is disabled while rst is high.
`ifndef TURTLE_PATH_INTERPRETER_ASSERT_SVH
`define TURTLE_PATH_INTERPRETER_ASSERT_SVH

// Condition that must hold at every rising clock edge outside reset.
`define TPI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define TPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tpi_pkg.sv]
// Shared types and constants for the turtle path interpreter.
// No dependencies; imported by turtle_path_interpreter.
`timescale 1ns / 1ps

package tpi_pkg;

  // Signed Q16.8 screen coordinate.
  typedef logic signed [23:0] pos_t;
  // Binary angle, 65536 counts per full turn.
  typedef logic [15:0] angle_t;

  // One saved turtle on the bracket stack.
  typedef struct packed {
    pos_t   x;
    pos_t   y;
    angle_t heading;
  } turtle_t;

  // Result fault codes.
  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_POP_EMPTY = 2'd1,
    FAULT_PUSH_FULL = 2'd2,
    FAULT_SATURATED = 2'd3
  } fault_t;

  // Screen home position (center of a 1280 x 1024 screen) in Q16.8.
  localparam pos_t HOME_X = 24'sd163840;
  localparam pos_t HOME_Y = 24'sd131072;

  localparam logic signed [25:0] POS_MAX = 26'sd8388607;
  localparam logic signed [25:0] POS_MIN = -26'sd8388608;

  localparam angle_t QUARTER_TURN = 16'h4000;

  // Symbol codes.
  localparam logic [7:0] SYM_DRAW  = 8'h46;  // F
  localparam logic [7:0] SYM_MOVE  = 8'h66;  // f
  localparam logic [7:0] SYM_LEFT  = 8'h2B;  // +
  localparam logic [7:0] SYM_RIGHT = 8'h2D;  // -
  localparam logic [7:0] SYM_PUSH  = 8'h5B;  // [
  localparam logic [7:0] SYM_POP   = 8'h5D;  // ]

  // Configuration register indexes.
  localparam logic [7:0] REG_STEP_ANGLE  = 8'd0;
  localparam logic [7:0] REG_LINE_LENGTH = 8'd1;
  localparam logic [7:0] REG_LINE_WIDTH  = 8'd2;
  localparam logic [7:0] REG_DRAW_EVERY  = 8'd3;

  // Register reset values.
  localparam logic [15:0] STEP_ANGLE_RST  = 16'd3823;
  localparam logic [15:0] LINE_LENGTH_RST = 16'd25600;
  localparam logic [15:0] LINE_WIDTH_RST  = 16'd2560;

endpackage

[rtl/turtle_path_interpreter.sv]
// Turtle path interpreter: one symbol per cycle while results are taken, as in_ready
// falls while a result waits. The sine lookup, one multiply per axis, saturation, box
// update and the stack access all sit between the input and the result register.
// The stack keeps its top entry in a register and prefetches the one below from memory.
// Synchronous reset restores registers, turtle, box and an empty stack; the stack
// memory is not cleared, only the fill count.
// Depends on tpi_pkg and turtle_path_interpreter_assert.svh.
`timescale 1ns / 1ps
`include "turtle_path_interpreter_assert.svh"

module turtle_path_interpreter #(
  parameter int STACK_DEPTH  = 64,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  // symbol input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           symbol,
  input  logic                 restart,
  // result output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 drawn,
  output tpi_pkg::pos_t        from_x,
  output tpi_pkg::pos_t        from_y,
  output tpi_pkg::pos_t        to_x,
  output tpi_pkg::pos_t        to_y,
  output tpi_pkg::angle_t      heading_out,
  output tpi_pkg::pos_t        box_min_x,
  output tpi_pkg::pos_t        box_min_y,
  output tpi_pkg::pos_t        box_max_x,
  output tpi_pkg::pos_t        box_max_y,
  output logic [1:0]           fault
);
  import tpi_pkg::*;

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int IW = $clog2(SINE_ENTRIES + 1);
  localparam int PW = 14 + IW;

  // Configuration registers.
  logic [15:0] step_angle;
  logic [15:0] line_length;
  logic [15:0] line_width;
  logic        draw_every_letter;

  // Turtle and box state.
  pos_t        turtle_x, turtle_y;
  angle_t      heading;
  pos_t        min_x, min_y, max_x, max_y;
  logic [FW-1:0] fill;
  turtle_t     top;
  turtle_t     below;
  turtle_t     stack_mem [STACK_DEPTH];

  // Result register.
  logic        out_drawn;
  pos_t        out_from_x, out_from_y, out_to_x, out_to_y;
  angle_t      out_heading;
  pos_t        out_min_x, out_min_y, out_max_x, out_max_y;
  fault_t      out_fault;

  logic        accept;

  // Quarter-wave sine table, entry i = sin(90deg * i / SINE_ENTRIES) in Q1.15.
  logic [15:0] sine_rom [SINE_ENTRIES + 1];

  for (genvar i = 0; i <= SINE_ENTRIES; i++) begin : g_rom
    localparam logic [63:0] X  = (64'(i) << 30) / SINE_ENTRIES;
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T0 = 64'd172273;
    localparam logic [63:0] T1 = 64'd5026995 - ((X2 * T0) >> 30);
    localparam logic [63:0] T2 = 64'd85569306 - ((X2 * T1) >> 30);
    localparam logic [63:0] T3 = 64'd693598668 - ((X2 * T2) >> 30);
    localparam logic [63:0] T4 = 64'd1686629713 - ((X2 * T3) >> 30);
    localparam logic [63:0] S0 = (X * T4) >> 30;
    localparam logic [63:0] S1 = (S0 + 64'd16384) >> 15;
    localparam logic [63:0] SV = (S1 > 64'd32768) ? 64'd32768 : S1;
    assign sine_rom[i] = SV[15:0];
  end

  // Configuration port: always ready, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_angle        <= STEP_ANGLE_RST;
      line_length       <= LINE_LENGTH_RST;
      line_width        <= LINE_WIDTH_RST;
      draw_every_letter <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_ANGLE:  step_angle        <= cfg_data;
        REG_LINE_LENGTH: line_length       <= cfg_data;
        REG_LINE_WIDTH:  line_width        <= cfg_data;
        REG_DRAW_EVERY:  draw_every_letter <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The output register frees up when its result is taken in the same cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // State as seen by this symbol, after any restart.
  pos_t          eff_x, eff_y;
  angle_t        eff_heading;
  logic [FW-1:0] eff_fill;
  pos_t          eff_min_x, eff_min_y, eff_max_x, eff_max_y;

  always_comb begin
    if (restart) begin
      eff_x       = HOME_X;
      eff_y       = HOME_Y;
      eff_heading = '0;
      eff_fill    = '0;
      eff_min_x   = HOME_X;
      eff_min_y   = HOME_Y;
      eff_max_x   = HOME_X + pos_t'({8'd0, line_width});
      eff_max_y   = HOME_Y + pos_t'({8'd0, line_length});
    end else begin
      eff_x       = turtle_x;
      eff_y       = turtle_y;
      eff_heading = heading;
      eff_fill    = fill;
      eff_min_x   = min_x;
      eff_min_y   = min_y;
      eff_max_x   = max_x;
      eff_max_y   = max_y;
    end
  end

  // Sine lookup and scaling for both axes: lane 0 is sin(h), lane 1 is cos(h).
  angle_t              lane_angle [2];
  logic [PW-1:0]       lane_prod  [2];
  logic [IW-1:0]       lane_idx   [2];
  logic [15:0]         lane_mag   [2];
  logic [31:0]         lane_scale [2];
  logic [32:0]         lane_round [2];
  logic signed [18:0]  lane_off   [2];

  always_comb begin
    lane_angle[0] = eff_heading;
    lane_angle[1] = eff_heading + QUARTER_TURN;
    for (int k = 0; k < 2; k++) begin
      lane_prod[k] = {{IW{1'b0}}, lane_angle[k][13:0]} * PW'(SINE_ENTRIES);
      lane_idx[k]  = lane_prod[k][PW-1:14];
      if (lane_angle[k][14]) begin
        lane_idx[k] = IW'(SINE_ENTRIES) - lane_idx[k];
      end
      lane_mag[k]   = sine_rom[lane_idx[k]];
      lane_scale[k] = line_length * lane_mag[k];
      lane_round[k] = {1'b0, lane_scale[k]} + 33'd16384;
      lane_off[k]   = $signed({1'b0, lane_round[k][32:15]});
    end
  end

  // Move: x grows with sin, y shrinks with cos (screen y points down).
  logic signed [18:0] dx, dy;
  logic signed [25:0] sum_x, sum_y;
  pos_t               move_x, move_y;
  logic               move_sat;

  always_comb begin
    dx    = lane_angle[0][15] ? -lane_off[0] : lane_off[0];
    dy    = lane_angle[1][15] ? lane_off[1] : -lane_off[1];
    sum_x = 26'(eff_x) + 26'(dx);
    sum_y = 26'(eff_y) + 26'(dy);
    move_sat = 1'b0;
    if (sum_x > POS_MAX) begin
      move_x = pos_t'(POS_MAX); move_sat = 1'b1;
    end else if (sum_x < POS_MIN) begin
      move_x = pos_t'(POS_MIN); move_sat = 1'b1;
    end else begin
      move_x = pos_t'(sum_x);
    end
    if (sum_y > POS_MAX) begin
      move_y = pos_t'(POS_MAX); move_sat = 1'b1;
    end else if (sum_y < POS_MIN) begin
      move_y = pos_t'(POS_MIN); move_sat = 1'b1;
    end else begin
      move_y = pos_t'(sum_y);
    end
  end

  // Symbol decode and next state.
  pos_t          x_next, y_next;
  angle_t        heading_next;
  logic [FW-1:0] fill_calc, fill_next;
  turtle_t       top_next;
  logic          push_wr;
  logic          do_move, drawn_next;
  fault_t        fault_next;
  pos_t          min_x_next, min_y_next, max_x_next, max_y_next;

  always_comb begin
    x_next       = eff_x;
    y_next       = eff_y;
    heading_next = eff_heading;
    fill_calc    = eff_fill;
    top_next     = top;
    push_wr      = 1'b0;
    do_move      = 1'b0;
    drawn_next   = 1'b0;
    fault_next   = FAULT_NONE;

    unique case (symbol)
      SYM_DRAW: begin
        do_move    = 1'b1;
        drawn_next = 1'b1;
      end
      SYM_MOVE:  do_move = 1'b1;
      SYM_LEFT:  heading_next = eff_heading + step_angle;
      SYM_RIGHT: heading_next = eff_heading - step_angle;
      SYM_PUSH: begin
        if (eff_fill == FW'(STACK_DEPTH)) begin
          fault_next = FAULT_PUSH_FULL;
        end else begin
          // The old top spills to memory; the current turtle becomes the top.
          push_wr   = (eff_fill != '0);
          top_next  = '{x: eff_x, y: eff_y, heading: eff_heading};
          fill_calc = eff_fill + FW'(1);
        end
      end
      SYM_POP: begin
        if (eff_fill == '0) begin
          fault_next = FAULT_POP_EMPTY;
        end else begin
          x_next       = top.x;
          y_next       = top.y;
          heading_next = top.heading;
          top_next     = below;
          fill_calc    = eff_fill - FW'(1);
        end
      end
      default: begin
        if (draw_every_letter) begin
          do_move    = 1'b1;
          drawn_next = 1'b1;
        end
      end
    endcase

    if (do_move) begin
      x_next = move_x;
      y_next = move_y;
      if (move_sat) begin
        fault_next = FAULT_SATURATED;
      end
    end

    // Widen the running box to take in the new position.
    min_x_next = (x_next < eff_min_x) ? x_next : eff_min_x;
    min_y_next = (y_next < eff_min_y) ? y_next : eff_min_y;
    max_x_next = (x_next > eff_max_x) ? x_next : eff_max_x;
    max_y_next = (y_next > eff_max_y) ? y_next : eff_max_y;

    fill_next = accept ? fill_calc : fill;
  end

  // Stack memory: spill on push, prefetch the entry under the new top.
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          mem_we;

  assign mem_we    = accept && push_wr;
  assign mem_waddr = AW'(eff_fill - FW'(1));
  assign mem_raddr = AW'(fill_next - FW'(2));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= top;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      below <= top;
    end else begin
      below <= stack_mem[mem_raddr];
    end
  end

  // Turtle state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      turtle_x  <= HOME_X;
      turtle_y  <= HOME_Y;
      heading   <= '0;
      fill      <= '0;
      min_x     <= HOME_X;
      min_y     <= HOME_Y;
      max_x     <= HOME_X + pos_t'({8'd0, LINE_WIDTH_RST});
      max_y     <= HOME_Y + pos_t'({8'd0, LINE_LENGTH_RST});
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        turtle_x  <= x_next;
        turtle_y  <= y_next;
        heading   <= heading_next;
        min_x     <= min_x_next;
        min_y     <= min_y_next;
        max_x     <= max_x_next;
        max_y     <= max_y_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top         <= top_next;
      out_drawn   <= drawn_next;
      out_from_x  <= eff_x;
      out_from_y  <= eff_y;
      out_to_x    <= x_next;
      out_to_y    <= y_next;
      out_heading <= heading_next;
      out_min_x   <= min_x_next;
      out_min_y   <= min_y_next;
      out_max_x   <= max_x_next;
      out_max_y   <= max_y_next;
      out_fault   <= fault_next;
    end
  end

  assign drawn       = out_drawn;
  assign from_x      = out_from_x;
  assign from_y      = out_from_y;
  assign to_x        = out_to_x;
  assign to_y        = out_to_y;
  assign heading_out = out_heading;
  assign box_min_x   = out_min_x;
  assign box_min_y   = out_min_y;
  assign box_max_x   = out_max_x;
  assign box_max_y   = out_max_y;
  assign fault       = out_fault;

  // The turtle never leaves its own bounding box.
  `TPI_ASSERT_ALWAYS(a_box_holds_turtle, (min_x <= turtle_x) && (turtle_x <= max_x) && (min_y <= turtle_y) && (turtle_y <= max_y), "turtle outside bounding box")
  // A pending result always describes the current turtle state.
  `TPI_ASSERT_ALWAYS(a_result_matches_state, !out_valid || ((to_x == turtle_x) && (to_y == turtle_y) && (heading_out == heading)), "result does not match turtle state")
  // A pop on a non-empty stack drops the fill by one.
  `TPI_ASSERT_NEXT(a_pop_fill, accept && (symbol == SYM_POP) && !restart && (fill != '0), fill == $past(fill) - FW'(1), "pop did not decrement fill")
  // A push right after a restart always lands in the first slot.
  `TPI_ASSERT_NEXT(a_restart_push, accept && (symbol == SYM_PUSH) && restart, fill == FW'(1), "push after restart did not leave one entry")

endmodule

[tb/turtle_path_interpreter_test.sv]
// Self-checking testbench for turtle_path_interpreter: drives symbol and register
// transactions, predicts every result transaction and compares it field by field.
// Depends on tpi_pkg and the turtle_path_interpreter RTL.
`timescale 1ns / 1ps

module turtle_path_interpreter_test;
  import tpi_pkg::*;

  localparam int STACK_DEPTH       = 64;
  localparam int SINE_ENTRIES      = 256;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int DRAIN_CYCLES      = 8;
  localparam int RANDOM_WALK_ITEMS = 100;
  localparam int STRAIGHT_RUN      = 200;
  // A register index that the block does not decode.
  localparam logic [7:0] REG_SPARE = 8'hC4;

  typedef struct {
    logic [7:0] code;
    logic       fresh;
  } symbol_item_t;

  typedef struct {
    logic   drawn;
    pos_t   from_x, from_y, to_x, to_y;
    angle_t heading;
    pos_t   lo_x, lo_y, hi_x, hi_y;
    fault_t fault;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  symbol    = '0;
  logic        restart   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        drawn;
  pos_t        from_x, from_y, to_x, to_y;
  angle_t      heading_out;
  pos_t        box_min_x, box_min_y, box_max_x, box_max_y;
  logic [1:0]  fault;

  // Predicted turtle, stack, box and register copies.
  logic [15:0] quarter_sine [0:SINE_ENTRIES];
  angle_t      turn_step;
  logic [15:0] stride;
  logic [15:0] pen_width;
  logic        letters_draw;
  int          pen_x, pen_y;
  angle_t      pen_heading;
  turtle_t     saved_pen [STACK_DEPTH];
  int          saved_count;
  int          box_lo_x, box_lo_y, box_hi_x, box_hi_y;

  symbol_item_t symbol_queue [$];
  segment_t     expected_segments [$];

  int items_queued    = 0;
  int results_checked = 0;
  int drawn_count     = 0;
  int mismatch_count  = 0;
  int settings_used   = 0;
  int fault_tally [4] = '{0, 0, 0, 0};
  int cycle_count     = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int stall_left      = 0;

  turtle_path_interpreter #(
    .STACK_DEPTH (STACK_DEPTH),
    .SINE_ENTRIES(SINE_ENTRIES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol     (symbol),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drawn      (drawn),
    .from_x     (from_x),
    .from_y     (from_y),
    .to_x       (to_x),
    .to_y       (to_y),
    .heading_out(heading_out),
    .box_min_x  (box_min_x),
    .box_min_y  (box_min_y),
    .box_max_x  (box_max_x),
    .box_max_y  (box_max_y),
    .fault      (fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Turtle back at the screen center, empty stack, box from the current registers.
  function automatic void home_turtle();
    pen_x       = int'(HOME_X);
    pen_y       = int'(HOME_Y);
    pen_heading = '0;
    saved_count = 0;
    box_lo_x    = int'(HOME_X);
    box_lo_y    = int'(HOME_Y);
    box_hi_x    = int'(HOME_X) + int'(pen_width);
    box_hi_y    = int'(HOME_Y) + int'(stride);
  endfunction

  // Signed Q1.15 sine of a binary angle from the quarter-wave table.
  function automatic int signed_sine(angle_t a);
    int idx;
    int v;
    idx = (int'(a[13:0]) * SINE_ENTRIES) >>> 14;
    if (a[14]) idx = SINE_ENTRIES - idx;
    v = int'(quarter_sine[idx]);
    return a[15] ? -v : v;
  endfunction

  // Line length times a Q1.15 sine, rounded half away from zero, in Q16.8.
  function automatic int stretch(int s);
    longint mag;
    mag = (s < 0) ? -s : s;
    mag = (longint'(stride) * mag + 16384) >>> 15;
    return (s < 0) ? -int'(mag) : int'(mag);
  endfunction

  // One step along the heading; returns 1 when a coordinate saturates.
  function automatic logic step_forward();
    int   nx, ny;
    logic hit;
    hit = 1'b0;
    nx  = pen_x + stretch(signed_sine(pen_heading));
    ny  = pen_y - stretch(signed_sine(pen_heading + QUARTER_TURN));
    if (nx > int'(POS_MAX)) begin
      nx  = int'(POS_MAX);
      hit = 1'b1;
    end else if (nx < int'(POS_MIN)) begin
      nx  = int'(POS_MIN);
      hit = 1'b1;
    end
    if (ny > int'(POS_MAX)) begin
      ny  = int'(POS_MAX);
      hit = 1'b1;
    end else if (ny < int'(POS_MIN)) begin
      ny  = int'(POS_MIN);
      hit = 1'b1;
    end
    pen_x = nx;
    pen_y = ny;
    return hit;
  endfunction

  // Applies one symbol to the predicted turtle and returns the segment it reports.
  function automatic segment_t interpret_symbol(logic [7:0] code, logic fresh);
    segment_t seg;
    logic     hit;
    if (fresh) home_turtle();
    seg.from_x = pos_t'(pen_x);
    seg.from_y = pos_t'(pen_y);
    seg.drawn  = 1'b0;
    seg.fault  = FAULT_NONE;
    hit        = 1'b0;
    case (code)
      SYM_DRAW: begin
        seg.drawn = 1'b1;
        hit       = step_forward();
      end
      SYM_MOVE:  hit = step_forward();
      SYM_LEFT:  pen_heading = pen_heading + turn_step;
      SYM_RIGHT: pen_heading = pen_heading - turn_step;
      SYM_PUSH: begin
        if (saved_count >= STACK_DEPTH) begin
          seg.fault = FAULT_PUSH_FULL;
        end else begin
          saved_pen[saved_count] = '{x: pos_t'(pen_x), y: pos_t'(pen_y), heading: pen_heading};
          saved_count++;
        end
      end
      SYM_POP: begin
        if (saved_count == 0) begin
          seg.fault = FAULT_POP_EMPTY;
        end else begin
          saved_count--;
          pen_x       = int'(saved_pen[saved_count].x);
          pen_y       = int'(saved_pen[saved_count].y);
          pen_heading = saved_pen[saved_count].heading;
        end
      end
      default: begin
        if (letters_draw) begin
          seg.drawn = 1'b1;
          hit       = step_forward();
        end
      end
    endcase
    if (hit) seg.fault = FAULT_SATURATED;

    // The box takes in the turtle after every symbol.
    if (pen_x < box_lo_x) box_lo_x = pen_x;
    if (pen_y < box_lo_y) box_lo_y = pen_y;
    if (pen_x > box_hi_x) box_hi_x = pen_x;
    if (pen_y > box_hi_y) box_hi_y = pen_y;

    seg.to_x    = pos_t'(pen_x);
    seg.to_y    = pos_t'(pen_y);
    seg.heading = pen_heading;
    seg.lo_x    = pos_t'(box_lo_x);
    seg.lo_y    = pos_t'(box_lo_y);
    seg.hi_x    = pos_t'(box_hi_x);
    seg.hi_y    = pos_t'(box_hi_y);
    return seg;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void queue_symbol(logic [7:0] code, logic fresh);
    symbol_queue.insert(symbol_queue.size(), '{code: code, fresh: fresh});
    items_queued++;
  endfunction

  function automatic logic [7:0] pick_body();
    case ($urandom_range(9))
      0, 1, 2, 3: return SYM_DRAW;
      4:          return SYM_MOVE;
      5, 6:       return SYM_LEFT;
      7, 8:       return SYM_RIGHT;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_setting();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(4095));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Mostly well-formed branches with random bodies, plus noise and broken nesting.
  function automatic void queue_random_walk(int count);
    int start;
    int pick;
    int depth;
    start = items_queued;
    while (items_queued - start < count) begin
      pick = $urandom_range(19);
      if (pick < 12) begin
        depth = $urandom_range(1, 4);
        repeat (depth) begin
          queue_symbol(SYM_PUSH, 1'b0);
          repeat ($urandom_range(4)) queue_symbol(pick_body(), 1'b0);
        end
        repeat (depth) begin
          repeat ($urandom_range(2)) queue_symbol(pick_body(), 1'b0);
          queue_symbol(SYM_POP, 1'b0);
        end
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 8))
          queue_symbol(8'($urandom_range(255)), $urandom_range(15) == 0);
      end else if (pick < 19) begin
        // A stray pop, or a branch that a restart cuts off.
        if ($urandom_range(1) == 0) begin
          queue_symbol(SYM_POP, 1'b0);
        end else begin
          queue_symbol(SYM_PUSH, 1'b0);
          queue_symbol(pick_body(), 1'b1);
        end
      end else begin
        queue_symbol(pick_body(), 1'b1);
      end
    end
  endfunction

  // Register write transaction; the copy is updated when it is accepted.
  task automatic write_reg(logic [7:0] index, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_STEP_ANGLE:  turn_step    = value;
      REG_LINE_LENGTH: stride       = value;
      REG_LINE_WIDTH:  pen_width    = value;
      REG_DRAW_EVERY:  letters_draw = value[0];
      default: ;
    endcase
  endtask

  // Blocks until every queued symbol has been sent and every result has come back.
  // The check runs on the falling edge, once the rising-edge updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (symbol_queue.size() != 0 || in_valid || expected_segments.size() != 0);
  endtask

  // Symbol driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : symbol_driver
    symbol_item_t pending;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (symbol_queue.size() != 0) begin
        pending = symbol_queue.pop_front();
        in_valid <= 1'b1;
        symbol   <= pending.code;
        restart  <= pending.fresh;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: the stall pattern cycles through four modes, one of them stall-free.
  always @(posedge clk) begin : result_sink
    int odds;
    int longest;
    case (cycle_count[10:9])
      2'd0: begin
        odds    = 0;
        longest = 0;
      end
      2'd1: begin
        odds    = 3;
        longest = 2;
      end
      2'd2: begin
        odds    = 1;
        longest = 12;
      end
      default: begin
        odds    = 6;
        longest = 30;
      end
    endcase
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (odds > 0 && $urandom_range(odds) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(longest);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: checks each result transaction, then predicts each accepted symbol.
  always @(posedge clk) begin : result_monitor
    segment_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_segments.size() == 0) begin
          $error("Result transaction with no symbol outstanding");
          mismatch_count++;
        end else begin
          want = expected_segments.pop_front();
          check_field("drawn", want.drawn, drawn);
          check_field("from_x", want.from_x, from_x);
          check_field("from_y", want.from_y, from_y);
          check_field("to_x", want.to_x, to_x);
          check_field("to_y", want.to_y, to_y);
          check_field("heading_out", want.heading, heading_out);
          check_field("box_min_x", want.lo_x, box_min_x);
          check_field("box_min_y", want.lo_y, box_min_y);
          check_field("box_max_x", want.hi_x, box_max_x);
          check_field("box_max_y", want.hi_y, box_max_y);
          check_field("fault", want.fault, fault);
          results_checked++;
          drawn_count += want.drawn;
          fault_tally[want.fault]++;
        end
      end
      if (in_valid && in_ready) begin
        expected_segments.insert(expected_segments.size(),
                                 interpret_symbol(symbol, restart));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_segments.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    longint unsigned ang, sq, poly, amp;

    // Quarter-wave sine in Q1.15 from an odd polynomial evaluated in Q30.
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      ang  = i;
      ang  = (ang << 30) / SINE_ENTRIES;
      sq   = (ang * ang) >> 30;
      poly = 64'd172273;
      poly = 64'd5026995 - ((sq * poly) >> 30);
      poly = 64'd85569306 - ((sq * poly) >> 30);
      poly = 64'd693598668 - ((sq * poly) >> 30);
      poly = 64'd1686629713 - ((sq * poly) >> 30);
      amp  = (((ang * poly) >> 30) + 64'd16384) >> 15;
      if (amp > 64'd32768) amp = 64'd32768;
      quarter_sine[i] = amp[15:0];
    end

    turn_step     = STEP_ANGLE_RST;
    stride        = LINE_LENGTH_RST;
    pen_width     = LINE_WIDTH_RST;
    letters_draw  = 1'b0;
    home_turtle();
    settings_used = 1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every operation at the reset settings, a pop on an empty stack first.
    queue_symbol(SYM_POP, 1'b0);
    queue_symbol(SYM_DRAW, 1'b0);
    queue_symbol(SYM_LEFT, 1'b0);
    queue_symbol(SYM_DRAW, 1'b0);
    queue_symbol(SYM_PUSH, 1'b0);
    queue_symbol(SYM_RIGHT, 1'b0);
    queue_symbol(SYM_MOVE, 1'b0);
    queue_symbol(8'h41, 1'b0);
    queue_symbol(SYM_POP, 1'b0);
    queue_symbol(8'h00, 1'b0);
    queue_symbol(8'hFF, 1'b0);
    queue_symbol(SYM_DRAW, 1'b1);
    wait_idle();

    // Register extremes: zero length still draws, letters draw, undecoded index ignored.
    write_reg(REG_STEP_ANGLE, 16'hFFFF);
    write_reg(REG_LINE_LENGTH, 16'h0000);
    write_reg(REG_LINE_WIDTH, 16'hFFFF);
    write_reg(REG_DRAW_EVERY, 16'h0001);
    write_reg(REG_SPARE, 16'h1234);
    settings_used++;
    queue_symbol(SYM_DRAW, 1'b1);
    queue_symbol(8'h7A, 1'b0);
    queue_symbol(SYM_LEFT, 1'b0);
    queue_symbol(SYM_RIGHT, 1'b0);
    queue_symbol(SYM_RIGHT, 1'b0);
    queue_symbol(SYM_MOVE, 1'b0);
    wait_idle();

    // Long diagonal runs at full length drive both coordinates into saturation,
    // first up and right, then down and left.
    write_reg(REG_STEP_ANGLE, 16'h2000);
    write_reg(REG_LINE_LENGTH, 16'hFFFF);
    write_reg(REG_LINE_WIDTH, pick_setting());
    write_reg(REG_DRAW_EVERY, 16'h0001);
    settings_used++;
    for (int run = 0; run < 2; run++) begin
      if (run == 0) begin
        queue_symbol(SYM_LEFT, 1'b1);
      end else begin
        queue_symbol(SYM_RIGHT, 1'b1);
        queue_symbol(SYM_RIGHT, 1'b0);
        queue_symbol(SYM_RIGHT, 1'b0);
      end
      repeat (STRAIGHT_RUN) begin
        case ($urandom_range(2))
          0:       queue_symbol(SYM_DRAW, 1'b0);
          1:       queue_symbol(SYM_MOVE, 1'b0);
          default: queue_symbol(8'($urandom_range(8'h47, 8'h5A)), 1'b0);
        endcase
      end
    end
    wait_idle();

    // Random walks, each phase under freshly drawn register settings.
    for (int phase = 0; phase < 3; phase++) begin
      write_reg(REG_STEP_ANGLE, pick_setting());
      write_reg(REG_LINE_LENGTH, pick_setting());
      write_reg(REG_LINE_WIDTH, pick_setting());
      write_reg(REG_DRAW_EVERY, 16'($urandom_range(1)));
      settings_used++;
      if (phase == 0) begin
        // Nest past the stack depth, then unwind past empty.
        queue_symbol(SYM_DRAW, 1'b1);
        for (int d = 0; d < STACK_DEPTH + 2; d++) begin
          queue_symbol(SYM_PUSH, 1'b0);
          if (d % 8 == 0) queue_symbol(pick_body(), 1'b0);
        end
        repeat (STACK_DEPTH + 3) queue_symbol(SYM_POP, 1'b0);
      end
      queue_random_walk(RANDOM_WALK_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_segments.size() != 0) begin
      $error("%0d expected results never arrived", expected_segments.size());
      mismatch_count++;
    end
    $display("Sent %0d symbols under %0d register settings; %0d results checked, %0d drawn.",
             items_queued, settings_used, results_checked, drawn_count);
    $display("Faults seen: %0d saturated, %0d push on full, %0d pop on empty.",
             fault_tally[FAULT_SATURATED], fault_tally[FAULT_PUSH_FULL],
             fault_tally[FAULT_POP_EMPTY]);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
